@@ design/xcrc_rx_pkg.sv @@
// Package for the XMODEM-CRC packet receiver: codes, phases and the CRC-16 byte update.
`default_nettype none
package xcrc_rx_pkg;

    localparam int unsigned SHORT_PAYLOAD = 128;
    localparam int unsigned LONG_PAYLOAD  = 1024;
    localparam int unsigned SIZE_W        = 11;
    localparam int unsigned INDEX_W       = 10;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_CAN = 8'h18;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [8:0]  NUM_SUM  = 9'd255;
    localparam logic [7:0]  ERR_SAT  = 8'd255;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_BYTE    = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_FLASH   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_NUMBER    = 4'd1,
        PH_COMPL     = 4'd2,
        PH_DATA      = 4'd3,
        PH_CRC_HI    = 4'd4,
        PH_CRC_LO    = 4'd5,
        PH_DONE_EOT  = 4'd6,
        PH_DONE_HOST = 4'd7,
        PH_DONE_ERR  = 4'd8
    } t_phase;

    localparam logic [2:0] REPLY_NONE = 3'd0;
    localparam logic [2:0] REPLY_C    = 3'd1;
    localparam logic [2:0] REPLY_ACK  = 3'd2;
    localparam logic [2:0] REPLY_NAK  = 3'd3;
    localparam logic [2:0] REPLY_CAN2 = 3'd4;

    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_COMMIT  = 2'd1;
    localparam logic [1:0] VERDICT_DISCARD = 2'd2;

    localparam logic [1:0] STATUS_RUN  = 2'd0;
    localparam logic [1:0] STATUS_EOT  = 2'd1;
    localparam logic [1:0] STATUS_HOST = 2'd2;
    localparam logic [1:0] STATUS_ERR  = 2'd3;

    localparam logic [0:0] CFG_APP_BASE   = 1'd0;
    localparam logic [0:0] CFG_MAX_ERRORS = 1'd1;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ design/xmodem_crc_packet_receiver.sv @@
// XMODEM-CRC packet receiver: framing, checks, CRC-16, payload streaming and replies.
// Each accepted input beat writes its result beat into the output register.
// Throughput: one beat per cycle unless back-pressure stalls the output; all work of a beat
// is one pass through the phase logic and the byte-wide CRC update ahead of the result register.
// Reset (synchronous, active low): base address 0, max errors 3, session running and
// awaiting a header, output register empty.
`default_nettype none
module xmodem_crc_packet_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // rx_byte[7:0]
    input  wire logic [1:0]  i_s_axis_tuser,   // action[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // reply_code[2:0], data_byte[10:3], data_address[42:11], packet_verdict[44:43],
    // erase_request[45], session_status[47:46]
    output logic [47:0]      o_m_axis_tdata,
    output logic             o_m_axis_tuser    // data_valid
);

    // configuration
    logic [31:0] r_app_base;
    logic [7:0]  r_max_errors;

    // session state
    xcrc_rx_pkg::t_phase r_phase, n_phase;
    logic        r_first_seen, n_first_seen;
    logic [7:0]  r_expected, n_expected;
    logic [31:0] r_write_addr, n_write_addr;
    logic [7:0]  r_err_count, n_err_count;
    logic        r_long, n_long;
    logic [xcrc_rx_pkg::INDEX_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]  r_number, n_number;
    logic [7:0]  r_compl, n_compl;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;

    // output register
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        r_out_user;

    logic [2:0]  n_reply;
    logic        n_dvalid;
    logic [7:0]  n_dbyte;
    logic [31:0] n_daddr;
    logic [1:0]  n_verdict;
    logic        n_erase;
    logic [1:0]  n_status;

    logic        accept;
    xcrc_rx_pkg::t_action act;
    logic [7:0]  b;
    logic        ended, active;
    logic        in_header;
    logic        pkt_end, pkt_ok;
    logic        data_last;
    logic [xcrc_rx_pkg::SIZE_W-1:0] size;
    logic        err_event, discard;
    logic [7:0]  err_base, err_new;
    logic        err_abort;
    logic [15:0] crc_upd;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign act             = xcrc_rx_pkg::t_action'(i_s_axis_tuser);
    assign b               = i_s_axis_tdata;

    assign ended     = (r_phase == xcrc_rx_pkg::PH_DONE_EOT) ||
                       (r_phase == xcrc_rx_pkg::PH_DONE_HOST) ||
                       (r_phase == xcrc_rx_pkg::PH_DONE_ERR);
    assign active    = (act != xcrc_rx_pkg::ACT_START) && !ended;
    assign in_header = (r_phase == xcrc_rx_pkg::PH_HEADER);
    assign size      = r_long ? xcrc_rx_pkg::SIZE_W'(xcrc_rx_pkg::LONG_PAYLOAD)
                              : xcrc_rx_pkg::SIZE_W'(xcrc_rx_pkg::SHORT_PAYLOAD);
    assign data_last = ({1'b0, r_byte_index} + xcrc_rx_pkg::SIZE_W'(1)) >= size;
    assign crc_upd   = xcrc_rx_pkg::crc16_byte(r_crc, b);

    assign pkt_end = (act == xcrc_rx_pkg::ACT_BYTE) && (r_phase == xcrc_rx_pkg::PH_CRC_LO);
    assign pkt_ok  = (r_number == r_expected) &&
                     (({1'b0, r_number} + {1'b0, r_compl}) == xcrc_rx_pkg::NUM_SUM) &&
                     ({r_crc_hi, b} == r_crc);

    assign err_event = active && (
        ((act == xcrc_rx_pkg::ACT_BYTE) && in_header &&
            (b != xcrc_rx_pkg::BYTE_SOH) && (b != xcrc_rx_pkg::BYTE_STX) &&
            (b != xcrc_rx_pkg::BYTE_EOT) && (b != xcrc_rx_pkg::BYTE_CAN)) ||
        (pkt_end && !pkt_ok) ||
        ((act == xcrc_rx_pkg::ACT_TIMEOUT) && (!in_header || r_first_seen)) ||
        (act == xcrc_rx_pkg::ACT_FLASH));

    assign discard = active && ((pkt_end && !pkt_ok) ||
        (((act == xcrc_rx_pkg::ACT_TIMEOUT) || (act == xcrc_rx_pkg::ACT_FLASH)) && !in_header));

    // flash failure forces the count to the limit before the increment
    assign err_base  = (act == xcrc_rx_pkg::ACT_FLASH) ? r_max_errors : r_err_count;
    assign err_new   = (err_base == xcrc_rx_pkg::ERR_SAT) ? err_base : err_base + 8'd1;
    assign err_abort = err_new >= r_max_errors;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_first_seen = r_first_seen;
        n_expected   = r_expected;
        n_write_addr = r_write_addr;
        n_err_count  = r_err_count;
        n_long       = r_long;
        n_byte_index = r_byte_index;
        n_number     = r_number;
        n_compl      = r_compl;
        n_crc        = r_crc;
        n_crc_hi     = r_crc_hi;
        if (act == xcrc_rx_pkg::ACT_START) begin
            n_phase      = xcrc_rx_pkg::PH_HEADER;
            n_first_seen = 1'b0;
            n_expected   = 8'd1;
            n_write_addr = r_app_base;
            n_err_count  = 8'd0;
            n_long       = 1'b0;
            n_byte_index = '0;
            n_number     = 8'd0;
            n_compl      = 8'd0;
            n_crc        = 16'd0;
            n_crc_hi     = 8'd0;
        end else if (active) begin
            if (act == xcrc_rx_pkg::ACT_BYTE) begin
                unique case (r_phase)
                    xcrc_rx_pkg::PH_HEADER: begin
                        if ((b == xcrc_rx_pkg::BYTE_SOH) || (b == xcrc_rx_pkg::BYTE_STX)) begin
                            n_long  = (b == xcrc_rx_pkg::BYTE_STX);
                            n_phase = xcrc_rx_pkg::PH_NUMBER;
                        end else if (b == xcrc_rx_pkg::BYTE_EOT) begin
                            n_phase = xcrc_rx_pkg::PH_DONE_EOT;
                        end else if (b == xcrc_rx_pkg::BYTE_CAN) begin
                            n_phase = xcrc_rx_pkg::PH_DONE_HOST;
                        end
                    end
                    xcrc_rx_pkg::PH_NUMBER: begin
                        n_number = b;
                        n_phase  = xcrc_rx_pkg::PH_COMPL;
                    end
                    xcrc_rx_pkg::PH_COMPL: begin
                        n_compl      = b;
                        n_crc        = 16'd0;
                        n_byte_index = '0;
                        n_phase      = xcrc_rx_pkg::PH_DATA;
                    end
                    xcrc_rx_pkg::PH_DATA: begin
                        n_crc = crc_upd;
                        if (data_last) begin
                            n_byte_index = '0;
                            n_phase      = xcrc_rx_pkg::PH_CRC_HI;
                        end else begin
                            n_byte_index = r_byte_index + 1'b1;
                        end
                    end
                    xcrc_rx_pkg::PH_CRC_HI: begin
                        n_crc_hi = b;
                        n_phase  = xcrc_rx_pkg::PH_CRC_LO;
                    end
                    xcrc_rx_pkg::PH_CRC_LO: begin
                        n_first_seen = 1'b1;
                        if (pkt_ok) begin
                            n_expected   = r_expected + 8'd1;
                            n_write_addr = r_write_addr + 32'(size);
                            n_phase      = xcrc_rx_pkg::PH_HEADER;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (err_event) begin
                n_err_count = err_new;
                n_phase     = err_abort ? xcrc_rx_pkg::PH_DONE_ERR : xcrc_rx_pkg::PH_HEADER;
            end
        end
    end

    // result beat
    always_comb begin
        n_reply   = xcrc_rx_pkg::REPLY_NONE;
        n_dvalid  = 1'b0;
        n_dbyte   = 8'd0;
        n_daddr   = 32'd0;
        n_verdict = xcrc_rx_pkg::VERDICT_NONE;
        n_erase   = 1'b0;
        if (active) begin
            if (err_event) begin
                n_reply = err_abort ? xcrc_rx_pkg::REPLY_CAN2 : xcrc_rx_pkg::REPLY_NAK;
            end else if ((act == xcrc_rx_pkg::ACT_BYTE) && in_header &&
                         (b == xcrc_rx_pkg::BYTE_EOT)) begin
                n_reply = xcrc_rx_pkg::REPLY_ACK;
            end else if (pkt_end) begin
                n_reply = xcrc_rx_pkg::REPLY_ACK;
            end else if (act == xcrc_rx_pkg::ACT_TIMEOUT) begin
                n_reply = xcrc_rx_pkg::REPLY_C;
            end
            if ((act == xcrc_rx_pkg::ACT_BYTE) && (r_phase == xcrc_rx_pkg::PH_DATA)) begin
                n_dvalid = 1'b1;
                n_dbyte  = b;
                n_daddr  = r_write_addr + 32'(r_byte_index);
            end
            if (discard) begin
                n_verdict = xcrc_rx_pkg::VERDICT_DISCARD;
            end else if (pkt_end) begin
                n_verdict = xcrc_rx_pkg::VERDICT_COMMIT;
            end
            n_erase = pkt_end && !r_first_seen;
        end
        unique case (n_phase)
            xcrc_rx_pkg::PH_DONE_EOT:  n_status = xcrc_rx_pkg::STATUS_EOT;
            xcrc_rx_pkg::PH_DONE_HOST: n_status = xcrc_rx_pkg::STATUS_HOST;
            xcrc_rx_pkg::PH_DONE_ERR:  n_status = xcrc_rx_pkg::STATUS_ERR;
            default:                   n_status = xcrc_rx_pkg::STATUS_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_base   <= 32'd0;
            r_max_errors <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                xcrc_rx_pkg::CFG_APP_BASE:   r_app_base   <= i_cfg_data;
                xcrc_rx_pkg::CFG_MAX_ERRORS: r_max_errors <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= xcrc_rx_pkg::PH_HEADER;
            r_first_seen <= 1'b0;
            r_expected   <= 8'd1;
            r_write_addr <= 32'd0;
            r_err_count  <= 8'd0;
            r_long       <= 1'b0;
            r_byte_index <= '0;
            r_number     <= 8'd0;
            r_compl      <= 8'd0;
            r_crc        <= 16'd0;
            r_crc_hi     <= 8'd0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_first_seen <= n_first_seen;
            r_expected   <= n_expected;
            r_write_addr <= n_write_addr;
            r_err_count  <= n_err_count;
            r_long       <= n_long;
            r_byte_index <= n_byte_index;
            r_number     <= n_number;
            r_compl      <= n_compl;
            r_crc        <= n_crc;
            r_crc_hi     <= n_crc_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {n_status, n_erase, n_verdict, n_daddr, n_dbyte, n_reply};
            r_out_user <= n_dvalid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
`default_nettype wire
